// ===== rtl/core/lmb_pkg.sv =====
// ----------------------------------------------------------------------------
// lmb_pkg
// Shared constants for the local mean binarizer.
// ----------------------------------------------------------------------------
package lmb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 15;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int RING_W   = $clog2(2 * MAX_RADIUS + 2);
    localparam int ADDR_W   = RING_W + COL_W;
    localparam int RAD_W    = 4;
    localparam int DIM_W    = 11;
    localparam int BRIGHT_W = 10;
    localparam int POS_W    = 21;
    localparam int SUM_W    = 20;
    localparam int SPAN_W   = 6;
    localparam int CNT_W    = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic REQ_PIXEL = 1'b0;

    localparam logic [7:0] LEVEL_BLACK = 8'h00;
    localparam logic [7:0] LEVEL_WHITE = 8'hff;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 4'd1;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

endpackage

// ===== rtl/core/lmb_pix_if.sv =====
// ----------------------------------------------------------------------------
// lmb_pix_if
// Pixel input channel.
// ----------------------------------------------------------------------------
interface lmb_pix_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, req_type, red, green, blue, input ready);
    modport sink   (input valid, req_type, red, green, blue, output ready);
endinterface

// ===== rtl/core/lmb_res_if.sv =====
// ----------------------------------------------------------------------------
// lmb_res_if
// Binarized result channel.
// ----------------------------------------------------------------------------
interface lmb_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] level;
    logic       last_of_frame;

    modport source (output valid, level, last_of_frame, input ready);
    modport sink   (input valid, level, last_of_frame, output ready);
endinterface

// ===== rtl/core/lmb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lmb_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface lmb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lmb_line_ram.sv =====
// ----------------------------------------------------------------------------
// lmb_line_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lmb_line_ram #(
    parameter int DATA_W = 10,
    parameter int ADDR_W = 15
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/local_mean_binarizer.sv =====
// ----------------------------------------------------------------------------
// local_mean_binarizer
// Local mean adaptive threshold over a ring of stored brightness rows.
//
//   channel  dir  payload                          accepted when
//   pix      in   req_type, red, green, blue       pix.valid & pix.ready
//   res      out  level, last_of_frame             res.valid & res.ready
//   cfg      in   index, data                      cfg.valid & cfg.ready
//
// An item that gives no result leaves the block idle. For an item that gives a
// result, the window of N = (y1-y0+1)*(x1-x0+1) entries is summed one line
// store read per cycle through a single read port. The sum then passes
// through S_WAIT, S_CALC and S_CMP before the result is offered in S_OUT,
// where it is held while res.ready is low. The block returns to S_IDLE once
// the result is taken and only then takes the next item.
// Reset restores the register defaults and starts a new frame; the line store
// is not cleared. Only one item is in flight: pix.ready is low from accept
// until its result is taken. A configuration write is taken only while no
// item is in flight, and it has priority over a waiting pixel item.
// ----------------------------------------------------------------------------
module local_mean_binarizer (
    input  logic    clk,
    input  logic    rst_n,
    lmb_pix_if.sink pix,
    lmb_res_if.source res,
    lmb_cfg_if.sink cfg
);
    import lmb_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WAIT, S_CALC, S_CMP, S_OUT} state_t;

    state_t                state_reg;
    logic [RAD_W-1:0]      radius_reg;
    logic [DIM_W-1:0]      fwidth_reg;
    logic [DIM_W-1:0]      fheight_reg;
    logic [POS_W-1:0]      in_pos_reg;
    logic [ROW_W-1:0]      in_row_reg;
    logic [COL_W-1:0]      in_col_reg;
    logic [POS_W-1:0]      out_pos_reg;
    logic [ROW_W-1:0]      out_row_reg;
    logic [COL_W-1:0]      out_col_reg;
    logic [ROW_W-1:0]      y0_reg, y1_reg, y_reg;
    logic [COL_W-1:0]      x0_reg, x1_reg, x_reg;
    logic                  rd_valid_reg;
    logic                  rd_center_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [BRIGHT_W-1:0]   center_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [7:0]            level_reg;
    logic                  last_reg;

    logic [DIM_W-1:0]      w_eff, h_eff;
    logic [POS_W-1:0]      total;
    logic [POS_W-1:0]      delay;
    logic                  pix_acc, cfg_acc, is_pix, emit;
    logic [BRIGHT_W-1:0]   bright;
    logic [DIM_W-1:0]      row_hi, col_hi;
    logic [ROW_W-1:0]      y0_next, y1_next;
    logic [COL_W-1:0]      x0_next, x1_next;
    logic [SPAN_W-1:0]     dy, dx;
    logic [SUM_W-1:0]      nb_sum;
    logic [SUM_W-1:0]      ctr_prod;
    logic [POS_W-1:0]      out_pos_inc;
    logic [BRIGHT_W-1:0]   rdata;
    logic                  ram_we;

    always_comb
    begin
        w_eff = (fwidth_reg == '0) ? DIM_W'(1)
              : (fwidth_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fwidth_reg;
        h_eff = (fheight_reg == '0) ? DIM_W'(1)
              : (fheight_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : fheight_reg;
        total = POS_W'(w_eff) * POS_W'(h_eff);
        delay = POS_W'(radius_reg) * POS_W'(w_eff) + POS_W'(radius_reg);
    end

    assign pix.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg.ready = (state_reg == S_IDLE);
    assign pix_acc   = pix.valid && pix.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;

    assign res.valid         = (state_reg == S_OUT);
    assign res.level         = level_reg;
    assign res.last_of_frame = last_reg;

    always_comb
    begin
        bright = BRIGHT_W'(pix.red) + BRIGHT_W'(pix.green) + BRIGHT_W'(pix.blue);
        is_pix = (pix.req_type == REQ_PIXEL) && (in_pos_reg < total);
        if (is_pix)
        begin
            emit = (out_pos_reg + delay) < (in_pos_reg + POS_W'(1));
        end
        else
        begin
            emit = (in_pos_reg >= total) && (out_pos_reg < total);
        end
        row_hi  = DIM_W'(out_row_reg) + DIM_W'(radius_reg);
        col_hi  = DIM_W'(out_col_reg) + DIM_W'(radius_reg);
        y0_next = (out_row_reg > ROW_W'(radius_reg)) ? out_row_reg - ROW_W'(radius_reg) : '0;
        x0_next = (out_col_reg > COL_W'(radius_reg)) ? out_col_reg - COL_W'(radius_reg) : '0;
        y1_next = (row_hi > h_eff - DIM_W'(1)) ? ROW_W'(h_eff - DIM_W'(1)) : ROW_W'(row_hi);
        x1_next = (col_hi > w_eff - DIM_W'(1)) ? COL_W'(w_eff - DIM_W'(1)) : COL_W'(col_hi);
        dy       = SPAN_W'(y1_reg - y0_reg) + SPAN_W'(1);
        dx       = SPAN_W'(x1_reg - x0_reg) + SPAN_W'(1);
        nb_sum   = sum_reg - SUM_W'(center_reg);
        ctr_prod = SUM_W'(center_reg) * SUM_W'(cnt_reg);
        out_pos_inc = out_pos_reg + POS_W'(1);
    end

    assign ram_we = pix_acc && is_pix;

    lmb_line_ram #(
        .DATA_W (BRIGHT_W),
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({in_row_reg[RING_W-1:0], in_col_reg}),
        .wdata (bright),
        .re    (state_reg == S_SCAN),
        .raddr ({y_reg[RING_W-1:0], x_reg}),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radius_reg    <= RADIUS_RESET;
            fwidth_reg    <= WIDTH_RESET;
            fheight_reg   <= HEIGHT_RESET;
            in_pos_reg    <= '0;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_pos_reg   <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            rd_center_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            rd_valid_reg  <= (state_reg == S_SCAN);
            rd_center_reg <= (state_reg == S_SCAN) && (y_reg == out_row_reg)
                             && (x_reg == out_col_reg);
            if (rd_valid_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(rdata);
                if (rd_center_reg)
                begin
                    center_reg <= rdata;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pix_acc)
                    begin
                        if (is_pix)
                        begin
                            in_pos_reg <= in_pos_reg + POS_W'(1);
                            if (DIM_W'(in_col_reg) == w_eff - DIM_W'(1))
                            begin
                                in_col_reg <= '0;
                                in_row_reg <= in_row_reg + ROW_W'(1);
                            end
                            else
                            begin
                                in_col_reg <= in_col_reg + COL_W'(1);
                            end
                        end
                        if (emit)
                        begin
                            y0_reg    <= y0_next;
                            y1_reg    <= y1_next;
                            x0_reg    <= x0_next;
                            x1_reg    <= x1_next;
                            y_reg     <= y0_next;
                            x_reg     <= x0_next;
                            sum_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (x_reg == x1_reg)
                    begin
                        x_reg <= x0_reg;
                        if (y_reg == y1_reg)
                        begin
                            state_reg <= S_WAIT;
                        end
                        else
                        begin
                            y_reg <= y_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        x_reg <= x_reg + COL_W'(1);
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    cnt_reg   <= CNT_W'(dy) * CNT_W'(dx) - CNT_W'(1);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    level_reg <= (ctr_prod <= nb_sum) ? LEVEL_BLACK : LEVEL_WHITE;
                    last_reg  <= (out_pos_inc >= total);
                    if (out_pos_inc >= total)
                    begin
                        in_pos_reg  <= '0;
                        in_row_reg  <= '0;
                        in_col_reg  <= '0;
                        out_pos_reg <= '0;
                        out_row_reg <= '0;
                        out_col_reg <= '0;
                    end
                    else
                    begin
                        out_pos_reg <= out_pos_inc;
                        if (DIM_W'(out_col_reg) == w_eff - DIM_W'(1))
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + COL_W'(1);
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_acc)
            begin
                case (cfg.index)
                    REG_RADIUS: radius_reg  <= cfg.data[RAD_W-1:0];
                    REG_WIDTH:  fwidth_reg  <= cfg.data;
                    REG_HEIGHT: fheight_reg <= cfg.data;
                    default: ;
                endcase
                if (cfg.index == REG_RADIUS || cfg.index == REG_WIDTH
                    || cfg.index == REG_HEIGHT)
                begin
                    in_pos_reg  <= '0;
                    in_row_reg  <= '0;
                    in_col_reg  <= '0;
                    out_pos_reg <= '0;
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                end
            end
        end
    end

    a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_pos_reg <= in_pos_reg)
        else $error("output position ran ahead of input position");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready) |-> !res.valid)
        else $error("item accepted while a result is pending");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> ($past(state_reg) == S_SCAN))
        else $error("read data valid outside the window scan");

    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (y_reg >= y0_reg && y_reg <= y1_reg
                                   && x_reg >= x0_reg && x_reg <= x1_reg))
        else $error("scan address left the window");

endmodule
